// ===== rtl/core/clock_vfd_display_controller_assert.svh =====
// ============================================================================
// Assertion macros for the clock VFD display controller
// Shorthand for concurrent checks with and without reset masking.
// ============================================================================
`ifndef CLOCK_VFD_DISPLAY_CONTROLLER_ASSERT_SVH
`define CLOCK_VFD_DISPLAY_CONTROLLER_ASSERT_SVH

// same-cycle implication, masked during reset
`define CVFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cvfd check failed");

// next-cycle implication, masked during reset
`define CVFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cvfd check failed");

// next-cycle implication, always active
`define CVFD_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cvfd check failed");

`endif

// ===== rtl/core/cvfd_pkg.sv =====
// ============================================================================
// cvfd_pkg
// Shared constants, types and font functions of the clock VFD controller.
// ============================================================================
`default_nettype none

package cvfd_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int POS_W       = $clog2(DIGIT_COUNT);
    localparam int DATE_LEN    = 10;
    localparam int DATE_IDX_W  = $clog2(DATE_LEN);
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] STEP_RESET = 16'd500;
    localparam logic [7:0]  DOT_BIT    = 8'h80;
    localparam logic [7:0]  BLANK      = 8'h00;

    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_TIME  = 3'd1;
    localparam logic [2:0] KIND_ALARM = 3'd2;
    localparam logic [2:0] KIND_WDAY  = 3'd3;
    localparam logic [2:0] KIND_DATE  = 3'd4;

    typedef logic [1:0] t_op;
    localparam t_op OP_TICK = 2'd0;
    localparam t_op OP_LOAD = 2'd1;
    localparam t_op OP_DATE = 2'd2;

    typedef struct packed {
        t_op                             op;
        logic [DIGIT_COUNT-1:0][7:0]     glyph;
        logic [DIV_STEPS-1:0]            dividend;
    } t_job;

    localparam logic [7:0] GLYPHS [25] = '{
        8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F,
        8'h3F, 8'h7A, 8'h53, 8'h7C, 8'h5C, 8'h1C,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h38, 8'h78
    };

    localparam logic [7:0] CHAR_D = 8'h64;
    localparam logic [7:0] CHAR_O = 8'h6F;

    function automatic logic [7:0] font(input logic [7:0] c);
        logic [4:0] idx;
        logic       hit;
        idx = '0;
        hit = 1'b0;
        if (c <= 8'd9) begin
            idx = c[4:0];
            hit = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            idx = 5'(c - 8'h30);
            hit = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h6F) begin
            idx = 5'(c - 8'h61 + 8'd10);
            hit = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h4E) begin
            idx = 5'(c - 8'h41 + 8'd10);
            hit = 1'b1;
        end else if (c == 8'h4F) begin
            idx = 5'd0;
            hit = 1'b1;
        end
        return hit ? GLYPHS[idx] : BLANK;
    endfunction

    // reciprocal multiply, exact for values below 128
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v);
        logic [6:0] t;
        t = v - 7'(div10(v)) * 7'd10;
        return t[3:0];
    endfunction

    function automatic logic [7:0] font_tens(input logic [6:0] v);
        return font({4'd0, div10(v)});
    endfunction

    function automatic logic [7:0] font_units(input logic [6:0] v);
        return font({4'd0, mod10(v)});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cvfd_intf.sv =====
// ============================================================================
// cvfd channel interfaces
// Command channel and display output channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface cvfd_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [7:0]  day_code;
    logic        alarm_enabled;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [15:0] elapsed_ms;

    modport source (
        output valid, kind, hour, minute, second, day_code, alarm_enabled,
               year, month, day_of_month, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, kind, hour, minute, second, day_code, alarm_enabled,
               year, month, day_of_month, elapsed_ms,
        output ready
    );
endinterface

interface cvfd_disp_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [7:0] grid_lines;

    modport source (output valid, segments, grid_lines, input ready);
    modport sink (input valid, segments, grid_lines, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/clock_vfd_display_controller.sv =====
// ============================================================================
// clock_vfd_display_controller
// Six-digit multiplexed VFD clock display controller with scan output.
// ============================================================================
//  channel   dir  handshake    contents
//  i_cmd     in   valid/ready  kind, time, alarm, weekday and date fields
//  o_disp    out  valid/ready  segments, grid_lines (one per scan tick)
//  i_cfg_*   in   write enable scroll_step_ms
//
//  Scan ticks and time, alarm and weekday commands complete from the idle state.
//  Date commands run a 17-step serial divider that forms the scroll offset,
//  then the write state writes the buffer.
//  A two-entry queue lets commands enter while the back end works or the
//  output register waits; a full queue drops i_cmd.ready.
//  Synchronous reset clears the buffer, scan index and queue, and sets the
//  scroll step to 500.
// ============================================================================
`default_nettype none

module clock_vfd_display_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cvfd_cmd_if.sink      i_cmd,
    cvfd_disp_if.source   o_disp,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data
);
    import cvfd_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_job  push_job;
    t_job  head_job;

    cvfd_front u_front (
        .in_ch    (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    cvfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    cvfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_valid  (q_valid),
        .i_head        (head_job),
        .o_pop         (pop),
        .out_ch        (o_disp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cvfd_front.sv =====
// ============================================================================
// cvfd_front
// Accept command transactions, classify them and render fixed glyphs.
// ============================================================================
`default_nettype none

module cvfd_front (
    cvfd_cmd_if.sink        in_ch,
    input  logic            i_q_full,
    output logic            o_push,
    output cvfd_pkg::t_job  o_job
);
    import cvfd_pkg::*;

    logic take;
    logic keep;

    assign in_ch.ready = !i_q_full;
    assign take        = in_ch.valid && !i_q_full;
    assign o_push      = take && keep;

    always_comb begin
        keep         = 1'b1;
        o_job.op     = OP_LOAD;
        o_job.glyph  = '0;
        o_job.dividend = DIV_STEPS'(in_ch.elapsed_ms) + DIV_STEPS'(1);
        case (in_ch.kind)
            KIND_TICK: begin
                o_job.op = OP_TICK;
            end
            KIND_TIME: begin
                o_job.glyph[0] = font_tens(7'(in_ch.hour));
                o_job.glyph[1] = font_units(7'(in_ch.hour));
                o_job.glyph[2] = font_tens(7'(in_ch.minute));
                o_job.glyph[3] = font_units(7'(in_ch.minute));
                o_job.glyph[4] = font_tens(7'(in_ch.second));
                o_job.glyph[5] = font_units(7'(in_ch.second));
            end
            KIND_ALARM: begin
                o_job.glyph[0] = font(CHAR_D) | (in_ch.alarm_enabled ? DOT_BIT : BLANK);
                o_job.glyph[1] = font(in_ch.day_code);
                o_job.glyph[2] = font_tens(7'(in_ch.hour));
                o_job.glyph[3] = font_units(7'(in_ch.hour));
                o_job.glyph[4] = font_tens(7'(in_ch.minute));
                o_job.glyph[5] = font_units(7'(in_ch.minute));
            end
            KIND_WDAY: begin
                o_job.glyph[0] = font(CHAR_D);
                o_job.glyph[1] = font(CHAR_O);
                o_job.glyph[3] = font(in_ch.day_code);
            end
            KIND_DATE: begin
                o_job.op       = OP_DATE;
                o_job.glyph[0] = font_tens(in_ch.year);
                o_job.glyph[1] = font_units(in_ch.year);
                o_job.glyph[2] = font_tens(7'(in_ch.month));
                o_job.glyph[3] = font_units(7'(in_ch.month));
                o_job.glyph[4] = font_tens(7'(in_ch.day_of_month));
                o_job.glyph[5] = font_units(7'(in_ch.day_of_month));
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvfd_queue.sv =====
// ============================================================================
// cvfd_queue
// Short job queue between the front and back halves.
// ============================================================================
`default_nettype none

module cvfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cvfd_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output cvfd_pkg::t_job  o_head
);
    import cvfd_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvfd_back.sv =====
// ============================================================================
// cvfd_back
// Execute queued jobs: buffer loads, date scroll division and scan ticks.
// ============================================================================
`default_nettype none

module cvfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_head_valid,
    input  cvfd_pkg::t_job  i_head,
    output logic            o_pop,
    cvfd_disp_if.source     out_ch
);
    import cvfd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]            r_state,   n_state;
    logic [7:0]            r_buf [DIGIT_COUNT];
    logic [7:0]            n_buf [DIGIT_COUNT];
    logic [POS_W-1:0]      r_pos,     n_pos;
    logic [15:0]           r_step;
    logic [15:0]           r_rem,     n_rem;
    logic [DIV_STEPS-1:0]  r_dvd,     n_dvd;
    logic [DIV_CNT_W-1:0]  r_cnt,     n_cnt;
    logic [2:0]            r_m7,      n_m7;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_seg,     n_seg;
    logic [7:0]            r_grid,    n_grid;

    logic [15:0]           step_eff;
    logic [16:0]           rem_sh;
    logic                  q_bit;
    logic [3:0]            m7_sh;
    logic                  out_free;
    logic [7:0]            text [DATE_LEN];
    logic [DATE_IDX_W-1:0] k;

    assign step_eff = (r_step == '0) ? 16'd1 : r_step;
    assign rem_sh   = {r_rem, r_dvd[DIV_STEPS-1]};
    assign q_bit    = (rem_sh >= {1'b0, step_eff});
    assign m7_sh    = {r_m7, q_bit};
    assign out_free = !r_out_valid || out_ch.ready;

    assign out_ch.valid      = r_out_valid;
    assign out_ch.segments   = r_seg;
    assign out_ch.grid_lines = r_grid;

    always_comb begin
        text[0] = BLANK;
        text[1] = BLANK;
        text[2] = font(8'd2);
        text[3] = font(8'd0);
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            text[j + 4] = i_head.glyph[j];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_m7        = r_m7;
        n_seg       = r_seg;
        n_grid      = r_grid;
        n_out_valid = r_out_valid && !out_ch.ready;
        o_pop       = 1'b0;
        k           = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.op)
                        OP_TICK: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_seg       = r_buf[r_pos];
                                n_grid      = ~(8'd1 << r_pos);
                                n_pos       = (r_pos == POS_W'(DIGIT_COUNT - 1)) ?
                                              '0 : r_pos + 1'b1;
                            end
                        end
                        OP_LOAD: begin
                            o_pop = 1'b1;
                            for (int j = 0; j < DIGIT_COUNT; j++) begin
                                n_buf[j] = i_head.glyph[j];
                            end
                        end
                        OP_DATE: begin
                            n_rem   = '0;
                            n_dvd   = i_head.dividend;
                            n_m7    = '0;
                            n_cnt   = DIV_CNT_W'(DIV_STEPS);
                            n_state = ST_DIV;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem = q_bit ? 16'(rem_sh - {1'b0, step_eff}) : rem_sh[15:0];
                n_dvd = {r_dvd[DIV_STEPS-2:0], 1'b0};
                n_m7  = (m7_sh >= 4'd7) ? 3'(m7_sh - 4'd7) : m7_sh[2:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_pop   = 1'b1;
                n_state = ST_IDLE;
                for (int j = 0; j < DIGIT_COUNT; j++) begin
                    k = DATE_IDX_W'(j) + DATE_IDX_W'(r_m7);
                    n_buf[j] = (k < DATE_IDX_W'(DATE_LEN)) ? text[k] : BLANK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_step      <= STEP_RESET;
            r_out_valid <= 1'b0;
            for (int j = 0; j < DIGIT_COUNT; j++) begin
                r_buf[j] <= BLANK;
            end
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_buf       <= n_buf;
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_cnt  <= n_cnt;
        r_m7   <= n_m7;
        r_seg  <= n_seg;
        r_grid <= n_grid;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvfd_checker.sv =====
// ============================================================================
// cvfd_checker
// Port-level checks of the display output channel, bound to the top level.
// ============================================================================
`default_nettype none

`include "clock_vfd_display_controller_assert.svh"

module cvfd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic [7:0] i_segments,
    input  logic [7:0] i_grid_lines
);

    logic stall;
    logic grid_ok;

    assign stall   = i_valid && !i_ready;
    assign grid_ok = ($countones(~i_grid_lines) == 1) && (i_grid_lines[7:6] == 2'b11);

    `CVFD_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, stall, i_valid)
    `CVFD_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, stall, $stable({i_segments, i_grid_lines}))
    `CVFD_ASSERT_SAME(a_grid_single, i_clk, i_rst_n, i_valid, grid_ok)
    `CVFD_ASSERT_NEXT_RAW(a_reset_idle, i_clk, !i_rst_n, !i_valid)

endmodule

bind clock_vfd_display_controller cvfd_checker u_cvfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_disp.valid),
    .i_ready      (o_disp.ready),
    .i_segments   (o_disp.segments),
    .i_grid_lines (o_disp.grid_lines)
);

`default_nettype wire
